// ===== rtl/iarg_pkg.sv =====
// Package for the radix-grouped integer to ASCII converter.
// Shared sizes, base codes, character codes and the queued job type.
// No dependencies.
`default_nettype none
package iarg_pkg;
    localparam int VALUE_WIDTH      = 64;
    localparam int FLAGS_W          = 4;
    localparam int CHARS_PER_RESULT = 4;
    localparam int GROUP_SIZE       = 3;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

    localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BIN_DIGITS = VALUE_WIDTH;
    localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int DIG_W      = 4 * DEC_DIGITS;
    localparam int CNT_W      = $clog2(BIN_DIGITS + 1);
    localparam int KM_W       = $clog2(GROUP_SIZE);

    localparam int CHARS_W     = 8 * CHARS_PER_RESULT;
    localparam int CCNT_W      = 3;
    localparam int IN_TDATA_W  = ((VALUE_WIDTH + FLAGS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CHARS_W + CCNT_W + 7) / 8) * 8;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_BIN = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPA   = 8'h41;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [1:0]             base;
        logic                   grouped;
        logic [7:0]             sep;
        logic [CNT_W-1:0]       k_init;
        logic [KM_W-1:0]        kmod_init;
    } t_job;
endpackage
`default_nettype wire

// ===== rtl/iarg_fifo.sv =====
// Short job queue between the classifier and the conversion engine.
// Depends on iarg_pkg (t_job, QUEUE_DEPTH).
`default_nettype none
module iarg_fifo import iarg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_data,
    output logic      o_empty
);
    logic [QPTR_W:0] r_wr, r_rd;
    t_job            r_mem [QUEUE_DEPTH];

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[QPTR_W] != r_rd[QPTR_W]) &&
                     (r_wr[QPTR_W-1:0] == r_rd[QPTR_W-1:0]);
    assign o_data  = r_mem[r_rd[QPTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr[QPTR_W-1:0]] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/iarg_front.sv =====
// Input side: accepts items, decodes the format word into a job, queues it.
// Depends on iarg_pkg and iarg_fifo.
`default_nettype none
module iarg_front import iarg_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic                  i_pop,
    output t_job                       o_job,
    output logic                       o_job_valid
);
    logic [FLAGS_W-1:0] flags;
    t_job               job;
    logic               full, empty;

    assign flags = i_s_axis_tdata[VALUE_WIDTH +: FLAGS_W];

    always_comb begin
        job.value   = i_s_axis_tdata[VALUE_WIDTH-1:0];
        job.base    = flags[1:0];
        job.grouped = flags[2] | flags[3];
        job.sep     = flags[2] ? CH_COMMA : CH_DOT;
        unique case (flags[1:0])
            BASE_DEC: begin
                job.k_init    = CNT_W'(DEC_DIGITS);
                job.kmod_init = KM_W'(DEC_DIGITS % GROUP_SIZE);
            end
            BASE_BIN: begin
                job.k_init    = CNT_W'(BIN_DIGITS);
                job.kmod_init = KM_W'(BIN_DIGITS % GROUP_SIZE);
            end
            BASE_OCT: begin
                job.k_init    = CNT_W'(OCT_DIGITS);
                job.kmod_init = KM_W'(OCT_DIGITS % GROUP_SIZE);
            end
            default: begin
                job.k_init    = CNT_W'(HEX_DIGITS);
                job.kmod_init = KM_W'(HEX_DIGITS % GROUP_SIZE);
            end
        endcase
    end

    iarg_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_axis_tvalid),
        .i_data  (job),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_data  (o_job),
        .o_empty (empty)
    );

    assign o_s_axis_tready = !full;
    assign o_job_valid     = !empty;
endmodule
`default_nettype wire

// ===== rtl/iarg_back.sv =====
// Conversion engine: double-dabble for decimal, leading-zero skip, one
// character per cycle while not stalled, into a result packer with
// an output register. Depends on iarg_pkg.
`default_nettype none
module iarg_back import iarg_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_job_valid,
    input  wire t_job                   i_job,
    output logic                        o_pop,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                        o_m_axis_tlast
);
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DABBLE = 2'd1;
    localparam logic [1:0] ST_SKIP   = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    localparam int HEX_SH = DIG_W - 4 * HEX_DIGITS;
    localparam int OCT_SH = DIG_W - 3 * OCT_DIGITS;
    localparam int BIN_SH = DIG_W - BIN_DIGITS;

    function automatic logic [DIG_W-1:0] bcd_adjust(input logic [DIG_W-1:0] b);
        logic [DIG_W-1:0] r;
        r = b;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r[4*i +: 4] >= 4'd5) begin
                r[4*i +: 4] = r[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    logic [1:0]             r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [DIG_W-1:0]       r_dig, n_dig;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [CNT_W-1:0]       r_k, n_k;
    logic [KM_W-1:0]        r_kmod, n_kmod;
    logic [1:0]             r_base, n_base;
    logic                   r_grp, n_grp;
    logic [7:0]             r_sep, n_sep;
    logic                   r_sep_pend, n_sep_pend;
    logic [CHARS_W-1:0]     r_word, n_word;
    logic [CCNT_W-1:0]      r_n, n_n;
    logic                   r_ovalid, n_ovalid;
    logic [CHARS_W-1:0]     r_ochars, n_ochars;
    logic [CCNT_W-1:0]      r_ocnt, n_ocnt;
    logic                   r_olast, n_olast;

    logic [3:0]             top;
    logic [DIG_W-1:0]       dig_shl;
    logic [DIG_W-1:0]       dig_adj;
    logic [CNT_W-1:0]       k_dec;
    logic [KM_W-1:0]        kmod_dec;
    logic [7:0]             ch;
    logic [CHARS_W-1:0]     word_ins;
    logic [CCNT_W-1:0]      n_ins;
    logic                   done, out_free;

    always_comb begin
        unique case (r_base)
            BASE_BIN: begin
                top     = {3'b0, r_dig[DIG_W-1]};
                dig_shl = r_dig << 1;
            end
            BASE_OCT: begin
                top     = {1'b0, r_dig[DIG_W-1 -: 3]};
                dig_shl = r_dig << 3;
            end
            default: begin
                top     = r_dig[DIG_W-1 -: 4];
                dig_shl = r_dig << 4;
            end
        endcase
    end

    assign dig_adj  = bcd_adjust(r_dig);
    assign k_dec    = r_k - 1'b1;
    assign kmod_dec = (r_kmod == '0) ? KM_W'(GROUP_SIZE - 1) : r_kmod - 1'b1;
    assign out_free = !r_ovalid || i_m_axis_tready;
    assign done     = !r_sep_pend && (r_k == CNT_W'(1));

    always_comb begin
        if (r_sep_pend) begin
            ch = r_sep;
        end else if (top < 4'd10) begin
            ch = CH_ZERO + {4'b0, top};
        end else begin
            ch = CH_UPA + {4'b0, top} - 8'd10;
        end
        word_ins = r_word;
        for (int i = 0; i < CHARS_PER_RESULT; i++) begin
            if (r_n == CCNT_W'(CHARS_PER_RESULT - 1 - i)) begin
                word_ins[8*i +: 8] = ch;
            end
        end
        n_ins = r_n + 1'b1;
    end

    always_comb begin
        n_state    = r_state;
        n_val      = r_val;
        n_dig      = r_dig;
        n_cnt      = r_cnt;
        n_k        = r_k;
        n_kmod     = r_kmod;
        n_base     = r_base;
        n_grp      = r_grp;
        n_sep      = r_sep;
        n_sep_pend = r_sep_pend;
        n_word     = r_word;
        n_n        = r_n;
        n_ovalid   = r_ovalid && !i_m_axis_tready;
        n_ochars   = r_ochars;
        n_ocnt     = r_ocnt;
        n_olast    = r_olast;
        o_pop      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_pop      = 1'b1;
                    n_val      = i_job.value;
                    n_base     = i_job.base;
                    n_grp      = i_job.grouped;
                    n_sep      = i_job.sep;
                    n_k        = i_job.k_init;
                    n_kmod     = i_job.kmod_init;
                    n_sep_pend = 1'b0;
                    n_cnt      = '0;
                    n_word     = '0;
                    n_n        = '0;
                    unique case (i_job.base)
                        BASE_DEC: n_dig = '0;
                        BASE_BIN: n_dig = DIG_W'(i_job.value) << BIN_SH;
                        BASE_OCT: n_dig = DIG_W'(i_job.value) << OCT_SH;
                        default:  n_dig = DIG_W'(i_job.value) << HEX_SH;
                    endcase
                    n_state = (i_job.base == BASE_DEC) ? ST_DABBLE : ST_SKIP;
                end
            end
            ST_DABBLE: begin
                n_dig = {dig_adj[DIG_W-2:0], r_val[VALUE_WIDTH-1]};
                n_val = r_val << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_WIDTH - 1)) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top == 4'd0 && r_k > CNT_W'(1)) begin
                    n_dig  = dig_shl;
                    n_k    = k_dec;
                    n_kmod = kmod_dec;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            default: begin
                if (out_free) begin
                    if (r_sep_pend) begin
                        n_sep_pend = 1'b0;
                    end else begin
                        n_dig      = dig_shl;
                        n_k        = k_dec;
                        n_kmod     = kmod_dec;
                        n_sep_pend = r_grp && (k_dec != '0) && (kmod_dec == '0);
                    end
                    if (done || n_ins == CCNT_W'(CHARS_PER_RESULT)) begin
                        n_ovalid = 1'b1;
                        n_ochars = word_ins;
                        n_ocnt   = n_ins;
                        n_olast  = done;
                        n_word   = '0;
                        n_n      = '0;
                    end else begin
                        n_word = word_ins;
                        n_n    = n_ins;
                    end
                    if (done) begin
                        n_state = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_dig      <= n_dig;
        r_cnt      <= n_cnt;
        r_k        <= n_k;
        r_kmod     <= n_kmod;
        r_base     <= n_base;
        r_grp      <= n_grp;
        r_sep      <= n_sep;
        r_sep_pend <= n_sep_pend;
        r_word     <= n_word;
        r_n        <= n_n;
        r_ochars   <= n_ochars;
        r_ocnt     <= n_ocnt;
        r_olast    <= n_olast;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_ocnt, r_ochars});
    assign o_m_axis_tlast  = r_olast;
endmodule
`default_nettype wire

// ===== rtl/integer_to_ascii_radix_grouped.sv =====
// Top level of the radix-grouped integer to ASCII converter.
// Depends on iarg_pkg, iarg_front, iarg_back.
//
// Usage:
//   Slave stream: tdata = value (bits 63:0), format (bits 67:64: base in 1:0,
//   comma groups in 2, dot groups in 3); one item is one number.
//   Master stream: tdata = chars (31:0, first character in the top byte),
//   char_count (34:32); tlast marks the final beat of a number.
//   Items are decoded on entry and held in a two-entry job queue, so up to
//   two further numbers are taken while one is being converted.
//   Per number: the job is fetched, shift-and-add-3 runs for decimal (not for
//   the other bases), leading zero digits are skipped, then each output
//   character is emitted, separators included. Conversion time is set by
//   the one-character-per-cycle emitter, which waits while the receiver
//   stalls, and the one-bit-per-cycle decimal converter.
//   Reset (i_rst_n low, synchronous) empties the queue and drops any beat.
//   When the receiver stalls, the output register holds its beat and the
//   emitter waits; the queue keeps accepting until it is full.
`default_nettype none
module integer_to_ascii_radix_grouped import iarg_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // value, format_flags
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,   // chars, char_count
    output logic                        o_m_axis_tlast
);
    t_job job;
    logic job_valid, pop;

    iarg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_pop           (pop),
        .o_job           (job),
        .o_job_valid     (job_valid)
    );

    iarg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (job),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );
endmodule
`default_nettype wire

// ===== rtl/iarg_checker.sv =====
// Port-level checks for the converter top level, attached by bind.
// Depends on iarg_pkg and integer_to_ascii_radix_grouped.
`default_nettype none
module iarg_checker import iarg_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                   o_m_axis_tlast
);
    logic [CCNT_W-1:0] cnt;
    assign cnt = o_m_axis_tdata[CHARS_W +: CCNT_W];

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("beat shown right after reset");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (cnt != '0) && (cnt <= CCNT_W'(CHARS_PER_RESULT)))
        else $error("character count out of range");

    a_full_unless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> cnt == CCNT_W'(CHARS_PER_RESULT))
        else $error("short beat before end of number");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && cnt != CCNT_W'(CHARS_PER_RESULT) |-> o_m_axis_tdata[7:0] == 8'd0)
        else $error("unused character byte not zero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled beat changed");
endmodule

bind integer_to_ascii_radix_grouped iarg_checker u_checker (.*);
`default_nettype wire
